>>> design/ecpsm_pkg.sv
// ecpsm_pkg: shared types and constants for the prime-field scalar multiplier.
// No dependencies.
`timescale 1ns / 1ps

package ecpsm_pkg;

    localparam int DATA_W    = 16;   // width of every coordinate and register field
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_A = 1'b1;

    localparam logic [DATA_W-1:0] MODULUS_RST = 16'd9967;
    localparam logic [DATA_W-1:0] COEFF_A_RST = 16'd188;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL,     // bit-serial modular multiply, returns to ret_reg
        ST_RDX,
        ST_RDY,
        ST_RDA,
        ST_DBL,
        ST_CHK,
        ST_NEXT,
        ST_INV,     // extended Euclid, one quotient bit per cycle
        ST_INVFIN,
        ST_TAN1,
        ST_TAN2,
        ST_TAN3,
        ST_LAM,
        ST_X3A,
        ST_X3B,
        ST_Y3A,
        ST_Y3B,
        ST_OUT
    } state_t;

endpackage

>>> design/ec_prime_scalar_multiply.sv
// ec_prime_scalar_multiply: k*P on y^2 = x^3 + a*x + b over GF(m), affine coordinates.
// Depends on ecpsm_pkg.
`timescale 1ns / 1ps

// Left-to-right double-and-add scalar multiplier. One transfer on the s_ side
// carries k, x, y and an infinity flag; one transfer on the m_ side returns k*P
// (coordinates zero when the result is infinity). Inputs and a are reduced mod m
// first. A zero slope denominator, or one with no inverse, gives infinity; so do
// k = 0, an infinite input point and m < 3. The block takes one item at a time:
// s_tready is high only while idle. All arithmetic goes through a bit-serial
// modular multiplier and an extended-Euclid inverter that resolves one quotient
// bit per cycle. An item finishes sooner for short scalars and quickly ending
// inversions. Configuration writes are accepted every cycle and must only be
// made while idle.
module ec_prime_scalar_multiply
    import ecpsm_pkg::*;
#(
    parameter int FIELD_BITS  = 16,
    parameter int SCALAR_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input item
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // scalar[15:0], point_x[31:16], point_y[47:32]
    input  logic                 s_tuser,   // point_is_infinity
    // result item
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // result_x[15:0], result_y[31:16]
    output logic                 m_tuser,   // result_is_infinity
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    localparam int F  = FIELD_BITS;
    localparam int TW = FIELD_BITS + 2;            // signed Bezout coefficient
    localparam int CW = $clog2(FIELD_BITS);
    localparam int BW = $clog2(SCALAR_BITS);

    state_t state_reg, state_next, ret_reg, ret_next;

    logic [DATA_W-1:0] modulus_reg, coeff_a_reg;

    logic [SCALAR_BITS-1:0] k_reg, k_next;
    logic [BW-1:0]          bit_reg, bit_next;
    logic [F-1:0] px_reg, px_next, py_reg, py_next, ca_reg, ca_next;
    logic [F-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic         ainf_reg, ainf_next;
    logic [F-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic         tan_reg, tan_next, dbl_reg, dbl_next;
    logic [F-1:0] rw_reg, rw_next, r1_reg, r1_next;
    logic signed [TW-1:0] tw_reg, tw_next, t1_reg, t1_next;
    logic [CW-1:0] j_reg, j_next;
    logic [F-1:0] inv_reg, inv_next, lam_reg, lam_next, tmp_reg, tmp_next;
    logic [F-1:0] mul_a_reg, mul_a_next, mul_b_reg, mul_b_next;
    logic [F-1:0] mul_acc_reg, mul_acc_next;
    logic [CW-1:0] mul_cnt_reg, mul_cnt_next;

    logic [F-1:0] m;
    logic [SCALAR_BITS-1:0] k_in;
    logic bad_in;

    assign m      = F'(modulus_reg);
    assign k_in   = SCALAR_BITS'(s_tdata[15:0]);
    assign bad_in = (m < F'(3)) || s_tuser || (k_in == '0);

    function automatic logic [F-1:0] madd(input logic [F-1:0] u, input logic [F-1:0] v,
                                          input logic [F-1:0] md);
        logic [F:0] s;
        s = {1'b0, u} + {1'b0, v};
        if (s >= {1'b0, md}) s = s - {1'b0, md};
        return s[F-1:0];
    endfunction

    function automatic logic [F-1:0] msub(input logic [F-1:0] u, input logic [F-1:0] v,
                                          input logic [F-1:0] md);
        logic [F:0] s;
        if (u >= v) s = {1'b0, u} - {1'b0, v};
        else        s = {1'b0, u} + {1'b0, md} - {1'b0, v};
        return s[F-1:0];
    endfunction

    // one step of the shift-and-add modular multiplier
    logic [F:0] mul_t;
    logic [F-1:0] mul_step;
    always_comb begin
        mul_t = {mul_acc_reg, 1'b0};
        if (mul_t >= {1'b0, m}) mul_t = mul_t - {1'b0, m};
        if (mul_a_reg[F-1]) mul_t = mul_t + {1'b0, mul_b_reg};
        if (mul_t >= {1'b0, m}) mul_t = mul_t - {1'b0, m};
        mul_step = mul_t[F-1:0];
    end

    // one quotient bit of the Euclid division, coefficient updated alongside
    logic [2*F-1:0] div_sd;
    logic           div_take;
    logic [F-1:0]   rw_div;
    logic signed [TW-1:0] tw_div;
    always_comb begin
        div_sd   = (2*F)'(r1_reg) << j_reg;
        div_take = div_sd <= (2*F)'(rw_reg);
        rw_div   = div_take ? F'((2*F)'(rw_reg) - div_sd) : rw_reg;
        tw_div   = div_take ? tw_reg - (t1_reg << j_reg) : tw_reg;
    end

    // Bezout coefficient brought into [0, m)
    logic signed [TW-1:0] norm_t;
    logic [F-1:0] inv_val;
    always_comb begin
        norm_t = tw_reg;
        if (norm_t < 0) norm_t = norm_t + TW'(m);
        if (norm_t >= TW'(m)) norm_t = norm_t - TW'(m);
        inv_val = F'(norm_t);
    end

    logic [F-1:0] ay2, chord_den, dy;
    logic         same_pt, after_is_chk;
    assign ay2       = madd(ay_reg, ay_reg, m);
    assign chord_den = msub(px_reg, ax_reg, m);
    assign dy        = msub(qy_reg, ay_reg, m);
    assign same_pt   = (ax_reg == px_reg) && (ay_reg == py_reg);
    assign after_is_chk = dbl_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = bad_in ? ST_OUT : ST_MUL;
            ST_MUL:    if (mul_cnt_reg == '0) state_next = ret_reg;
            ST_RDX:    state_next = ST_MUL;
            ST_RDY:    state_next = ST_MUL;
            ST_RDA:    state_next = ST_DBL;
            ST_DBL:    state_next = ainf_reg ? ST_CHK : ST_INV;
            ST_CHK:    state_next = (k_reg[bit_reg] && !ainf_reg) ? ST_INV : ST_NEXT;
            ST_NEXT:   state_next = (bit_reg == '0) ? ST_OUT : ST_DBL;
            ST_INV: begin
                if (r1_reg == '0) state_next = ST_INVFIN;
                else if (j_reg == '0 && rw_div == '0) state_next = ST_INVFIN;
            end
            ST_INVFIN: begin
                if (rw_reg != F'(1)) state_next = after_is_chk ? ST_CHK : ST_NEXT;
                else state_next = ST_MUL;
            end
            ST_TAN1:   state_next = ST_TAN2;
            ST_TAN2:   state_next = ST_TAN3;
            ST_TAN3:   state_next = ST_MUL;
            ST_LAM:    state_next = ST_MUL;
            ST_X3A:    state_next = ST_X3B;
            ST_X3B:    state_next = ST_Y3A;
            ST_Y3A:    state_next = ST_MUL;
            ST_Y3B:    state_next = after_is_chk ? ST_CHK : ST_NEXT;
            ST_OUT:    if (m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        ret_next = ret_reg; k_next = k_reg; bit_next = bit_reg;
        px_next = px_reg; py_next = py_reg; ca_next = ca_reg;
        ax_next = ax_reg; ay_next = ay_reg; ainf_next = ainf_reg;
        qx_next = qx_reg; qy_next = qy_reg; tan_next = tan_reg; dbl_next = dbl_reg;
        rw_next = rw_reg; r1_next = r1_reg; tw_next = tw_reg; t1_next = t1_reg;
        j_next = j_reg; inv_next = inv_reg; lam_next = lam_reg; tmp_next = tmp_reg;
        mul_a_next = mul_a_reg; mul_b_next = mul_b_reg;
        mul_acc_next = mul_acc_reg; mul_cnt_next = mul_cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    k_next = k_in;
                    py_next = F'(s_tdata[47:32]);
                    ax_next = '0; ay_next = '0; ainf_next = 1'b1;
                    mul_a_next = F'(s_tdata[31:16]); mul_b_next = F'(1);
                    mul_acc_next = '0; mul_cnt_next = CW'(F-1); ret_next = ST_RDX;
                end
            end
            ST_MUL: begin
                mul_acc_next = mul_step;
                mul_a_next = mul_a_reg << 1;
                mul_cnt_next = mul_cnt_reg - CW'(1);
            end
            ST_RDX: begin
                px_next = mul_acc_reg;
                mul_a_next = py_reg; mul_b_next = F'(1);
                mul_acc_next = '0; mul_cnt_next = CW'(F-1); ret_next = ST_RDY;
            end
            ST_RDY: begin
                py_next = mul_acc_reg;
                mul_a_next = F'(coeff_a_reg); mul_b_next = F'(1);
                mul_acc_next = '0; mul_cnt_next = CW'(F-1); ret_next = ST_RDA;
            end
            ST_RDA: begin
                ca_next = mul_acc_reg;
                bit_next = BW'(SCALAR_BITS-1);
            end
            ST_DBL: begin
                dbl_next = 1'b1; tan_next = 1'b1;
                qx_next = ax_reg; qy_next = ay_reg;
                rw_next = m; tw_next = '0; r1_next = ay2; t1_next = TW'(1);
                j_next = CW'(F-1);
            end
            ST_CHK: begin
                if (k_reg[bit_reg]) begin
                    if (ainf_reg) begin
                        ax_next = px_reg; ay_next = py_reg; ainf_next = 1'b0;
                    end else begin
                        dbl_next = 1'b0;
                        qx_next = px_reg; qy_next = py_reg;
                        tan_next = same_pt;
                        r1_next = same_pt ? ay2 : chord_den;
                        rw_next = m; tw_next = '0; t1_next = TW'(1);
                        j_next = CW'(F-1);
                    end
                end
            end
            ST_NEXT: begin
                if (bit_reg != '0) bit_next = bit_reg - BW'(1);
            end
            ST_INV: begin
                if (r1_reg != '0) begin
                    if (j_reg == '0) begin
                        rw_next = r1_reg; r1_next = rw_div;
                        tw_next = t1_reg; t1_next = tw_div;
                        j_next = CW'(F-1);
                    end else begin
                        rw_next = rw_div; tw_next = tw_div;
                        j_next = j_reg - CW'(1);
                    end
                end
            end
            ST_INVFIN: begin
                if (rw_reg != F'(1)) begin
                    ainf_next = 1'b1; ax_next = '0; ay_next = '0;
                end else begin
                    inv_next = inv_val;
                    mul_acc_next = '0; mul_cnt_next = CW'(F-1);
                    if (tan_reg) begin
                        mul_a_next = ax_reg; mul_b_next = ax_reg; ret_next = ST_TAN1;
                    end else begin
                        mul_a_next = dy; mul_b_next = inv_val; ret_next = ST_LAM;
                    end
                end
            end
            ST_TAN1: begin
                tmp_next = mul_acc_reg;
                lam_next = madd(mul_acc_reg, mul_acc_reg, m);
            end
            ST_TAN2: lam_next = madd(lam_reg, tmp_reg, m);
            ST_TAN3: begin
                mul_a_next = madd(lam_reg, ca_reg, m); mul_b_next = inv_reg;
                mul_acc_next = '0; mul_cnt_next = CW'(F-1); ret_next = ST_LAM;
            end
            ST_LAM: begin
                lam_next = mul_acc_reg;
                mul_a_next = mul_acc_reg; mul_b_next = mul_acc_reg;
                mul_acc_next = '0; mul_cnt_next = CW'(F-1); ret_next = ST_X3A;
            end
            ST_X3A: tmp_next = msub(mul_acc_reg, ax_reg, m);
            ST_X3B: tmp_next = msub(tmp_reg, qx_reg, m);
            ST_Y3A: begin
                mul_a_next = msub(ax_reg, tmp_reg, m); mul_b_next = lam_reg;
                mul_acc_next = '0; mul_cnt_next = CW'(F-1); ret_next = ST_Y3B;
            end
            ST_Y3B: begin
                ax_next = tmp_reg;
                ay_next = msub(mul_acc_reg, ay_reg, m);
                ainf_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            modulus_reg <= MODULUS_RST;
            coeff_a_reg <= COEFF_A_RST;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_MODULUS: modulus_reg <= cfg_data;
                    CFG_COEFF_A: coeff_a_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        ret_reg <= ret_next; k_reg <= k_next; bit_reg <= bit_next;
        px_reg <= px_next; py_reg <= py_next; ca_reg <= ca_next;
        ax_reg <= ax_next; ay_reg <= ay_next; ainf_reg <= ainf_next;
        qx_reg <= qx_next; qy_reg <= qy_next; tan_reg <= tan_next; dbl_reg <= dbl_next;
        rw_reg <= rw_next; r1_reg <= r1_next; tw_reg <= tw_next; t1_reg <= t1_next;
        j_reg <= j_next; inv_reg <= inv_next; lam_reg <= lam_next; tmp_reg <= tmp_next;
        mul_a_reg <= mul_a_next; mul_b_reg <= mul_b_next;
        mul_acc_reg <= mul_acc_next; mul_cnt_reg <= mul_cnt_next;
    end

    // handshakes and result
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tuser   = ainf_reg;
    assign m_tdata   = ainf_reg ? 32'd0 : {DATA_W'(ay_reg), DATA_W'(ax_reg)};

endmodule
